// ===== src/iee_pkg.sv =====
`default_nettype none
package iee_pkg;

  localparam int VALUE_W = 48;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MAG_W = 96;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_OPCHK, S_OPRD, S_RED0, S_RED1, S_RED2,
    S_ALU, S_WAIT, S_PUSHOP, S_TOP, S_TOPW, S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  // keep only the first error
  function automatic logic [1:0] set_err(input logic [1:0] cur, input logic [1:0] code);
    set_err = (cur == ST_OK) ? code : cur;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_mag(input logic neg,
                                                        input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim;
    lim = MAG_W'(VAL_MAX);
    if (neg) begin
      if (mag > lim) sat_mag = VAL_MIN;
      else sat_mag = -$signed(mag[VALUE_W-1:0]);
    end else begin
      if (mag > lim) sat_mag = VAL_MAX;
      else sat_mag = $signed(mag[VALUE_W-1:0]);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp(input logic signed [VALUE_W:0] s);
    if (s[VALUE_W] != s[VALUE_W-1]) clamp = s[VALUE_W] ? VAL_MIN : VAL_MAX;
    else clamp = s[VALUE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/iee_ram.sv =====
`default_nettype none
module iee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/iee_alu.sv =====
`default_nettype none
module iee_alu #(
  parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire iee_pkg::alu_req_t                   req,
  input  wire logic signed [iee_pkg::VALUE_W-1:0]  b,
  input  wire logic signed [iee_pkg::VALUE_W-1:0]  a,
  output iee_pkg::alu_rsp_t                        rsp,
  output logic signed      [iee_pkg::VALUE_W-1:0]  result
);

  localparam int VW = iee_pkg::VALUE_W;
  localparam int HW = VW / 2;
  localparam int DW = VW + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);

  logic                        mul_busy, div_busy, fin, done, dz;
  logic                        neg;
  logic [VW-1:0]               x, y;
  logic [2:0]                  k;
  logic [VW-1:0]               pp;
  logic [1:0]                  pp_sh;
  logic [iee_pkg::MAG_W-1:0]   prod, prod_next, mag;
  logic [VW-1:0]               rem;
  logic [DW-1:0]               dvd, quo;
  logic [CW-1:0]               cnt;
  logic [VW:0]                 trial;
  logic                        qbit;
  logic [VW-1:0]               bm, am;

  assign bm = b[VW-1] ? VW'(-b) : VW'(b);
  assign am = a[VW-1] ? VW'(-a) : VW'(a);

  always_comb begin
    prod_next = prod;
    if (k != 3'd0) begin
      prod_next = prod + (iee_pkg::MAG_W'(pp) << (HW * 32'(pp_sh)));
    end
  end

  assign trial = {rem, dvd[DW-1]};
  assign qbit  = trial >= {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      fin      <= 1'b0;
      done     <= 1'b0;
      dz       <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (req.start) begin
        neg <= b[VW-1] ^ a[VW-1];
        x   <= bm;
        y   <= am;
        dz  <= 1'b0;
        unique case (req.op)
          iee_pkg::OP_ADD: begin
            result <= iee_pkg::clamp((VW+1)'(b) + (VW+1)'(a));
            done   <= 1'b1;
          end
          iee_pkg::OP_SUB: begin
            result <= iee_pkg::clamp((VW+1)'(b) - (VW+1)'(a));
            done   <= 1'b1;
          end
          iee_pkg::OP_MUL: begin
            mul_busy <= 1'b1;
            k        <= 3'd0;
            prod     <= '0;
          end
          iee_pkg::OP_DIV: begin
            if (am == '0) begin
              result <= '0;
              dz     <= 1'b1;
              done   <= 1'b1;
            end else begin
              div_busy <= 1'b1;
              rem      <= '0;
              dvd      <= DW'(bm) << FRACTION_BITS;
              cnt      <= CW'(DW);
            end
          end
        endcase
      end
      if (mul_busy) begin
        // one 24x24 partial product a cycle, accumulate the one before
        prod <= prod_next;
        k    <= k + 3'd1;
        unique case (k)
          3'd0: begin pp <= x[HW-1:0] * y[HW-1:0];   pp_sh <= 2'd0; end
          3'd1: begin pp <= x[VW-1:HW] * y[HW-1:0];  pp_sh <= 2'd1; end
          3'd2: begin pp <= x[HW-1:0] * y[VW-1:HW];  pp_sh <= 2'd1; end
          3'd3: begin pp <= x[VW-1:HW] * y[VW-1:HW]; pp_sh <= 2'd2; end
          default: begin
            mul_busy <= 1'b0;
            mag      <= prod_next >> FRACTION_BITS;
            fin      <= 1'b1;
          end
        endcase
      end
      if (div_busy) begin
        rem <= qbit ? VW'(trial - {1'b0, y}) : trial[VW-1:0];
        quo <= {quo[DW-2:0], qbit};
        dvd <= dvd << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          div_busy <= 1'b0;
          mag      <= iee_pkg::MAG_W'({quo[DW-2:0], qbit});
          fin      <= 1'b1;
        end
      end
      if (fin) begin
        result <= iee_pkg::sat_mag(neg, mag);
        done   <= 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.div_zero = dz;

`ifndef SYNTHESIS
  a_one_op: assert property (@(posedge clk) disable iff (rst) !(mul_busy && div_busy))
    else $error("alu runs multiply and divide at once");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (mul_busy || div_busy) |-> !req.start)
    else $error("alu started while busy");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && dz) |-> result == '0)
    else $error("divide by zero must give zero");
`endif

endmodule
`default_nettype wire

// ===== src/infix_expression_evaluator.sv =====
`default_nettype none
// Evaluates an infix expression fed one ASCII character per request; the
// request marked last_char produces one result (value, status). An operator
// is compared with the top of the operator stack and, for each reduction it
// triggers, pops two operands through stack memory access and waits for the
// arithmetic unit, whose divider is a 64-step divider at the default. Both
// stacks live in single-port-read synchronous RAMs, so each pop needs a
// registered read.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH   = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          char_code,
  input  wire logic                                last_char,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [iee_pkg::VALUE_W-1:0]       value,
  output logic [1:0]                               status
);

  localparam int VW = iee_pkg::VALUE_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = $clog2(STACK_DEPTH + 1);

  iee_pkg::state_t state, state_next;

  logic                 accept, is_digit, is_op, emit_go;
  iee_pkg::op_t         in_op, inc_op, red_op;
  logic                 lst, flush, in_num, rd_pend;
  logic [1:0]           err;
  logic [VW-1:0]        acc;
  logic [NW-1:0]        opnd_cnt, opr_cnt;
  logic signed [VW-1:0] opa, opb, alu_res;
  logic [VW+4:0]        acc10;

  logic                 opnd_we, opr_we;
  logic [AW-1:0]        opnd_waddr, opnd_raddr, opr_waddr, opr_raddr;
  logic [VW-1:0]        opnd_wdata, opnd_rdata;
  logic [1:0]           opr_rdata;

  iee_pkg::alu_req_t    alu_req;
  iee_pkg::alu_rsp_t    alu_rsp;

  assign accept   = in_valid && !in_stall;
  assign is_digit = char_code >= iee_pkg::CH_ZERO && char_code <= iee_pkg::CH_NINE;
  assign emit_go  = !out_valid || !out_stall;
  assign acc10    = ((VW+5)'(acc) << 3) + ((VW+5)'(acc) << 1)
                  + ((VW+5)'(char_code - iee_pkg::CH_ZERO) << FRACTION_BITS);

  always_comb begin
    is_op = 1'b1;
    in_op = iee_pkg::OP_ADD;
    unique case (char_code)
      iee_pkg::CH_PLUS:  in_op = iee_pkg::OP_ADD;
      iee_pkg::CH_MINUS: in_op = iee_pkg::OP_SUB;
      iee_pkg::CH_STAR:  in_op = iee_pkg::OP_MUL;
      iee_pkg::CH_SLASH: in_op = iee_pkg::OP_DIV;
      default:           is_op = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iee_pkg::S_IDLE:
        if (accept) begin
          if (is_op && in_num) state_next = iee_pkg::S_OPCHK;
          else if (last_char) state_next = iee_pkg::S_FIN;
        end
      iee_pkg::S_FIN:   state_next = iee_pkg::S_OPCHK;
      iee_pkg::S_OPCHK:
        if (opr_cnt != '0) state_next = iee_pkg::S_OPRD;
        else state_next = flush ? iee_pkg::S_TOP : iee_pkg::S_PUSHOP;
      iee_pkg::S_OPRD:
        if (flush || opr_rdata[1] >= inc_op[1]) state_next = iee_pkg::S_RED0;
        else state_next = iee_pkg::S_PUSHOP;
      iee_pkg::S_RED0:  state_next = iee_pkg::S_RED1;
      iee_pkg::S_RED1:  state_next = iee_pkg::S_RED2;
      iee_pkg::S_RED2:  state_next = iee_pkg::S_ALU;
      iee_pkg::S_ALU:   state_next = iee_pkg::S_WAIT;
      iee_pkg::S_WAIT:  if (alu_rsp.done) state_next = iee_pkg::S_OPCHK;
      iee_pkg::S_PUSHOP: state_next = lst ? iee_pkg::S_FIN : iee_pkg::S_IDLE;
      iee_pkg::S_TOP:   state_next = iee_pkg::S_TOPW;
      iee_pkg::S_TOPW:  state_next = iee_pkg::S_EMIT;
      iee_pkg::S_EMIT:  if (emit_go) state_next = iee_pkg::S_IDLE;
      default:          state_next = iee_pkg::S_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    in_stall    = state != iee_pkg::S_IDLE;
    opnd_we     = 1'b0;
    opnd_waddr  = opnd_cnt[AW-1:0];
    opnd_wdata  = acc;
    opnd_raddr  = AW'(opnd_cnt - NW'(1));
    opr_we      = 1'b0;
    opr_waddr   = opr_cnt[AW-1:0];
    opr_raddr   = AW'(opr_cnt - NW'(1));
    alu_req.start = state == iee_pkg::S_ALU;
    alu_req.op    = red_op;
    unique case (state)
      iee_pkg::S_IDLE:
        opnd_we = accept && is_op && in_num && opnd_cnt < NW'(STACK_DEPTH);
      iee_pkg::S_FIN:
        opnd_we = in_num && opnd_cnt < NW'(STACK_DEPTH);
      iee_pkg::S_WAIT: begin
        opnd_wdata = alu_res;
        opnd_we    = alu_rsp.done && opnd_cnt < NW'(STACK_DEPTH);
      end
      iee_pkg::S_PUSHOP:
        opr_we = opr_cnt < NW'(STACK_DEPTH);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iee_pkg::S_IDLE;
      out_valid <= 1'b0;
      acc       <= '0;
      in_num    <= 1'b0;
      err       <= iee_pkg::ST_OK;
      opnd_cnt  <= '0;
      opr_cnt   <= '0;
      lst       <= 1'b0;
      flush     <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        iee_pkg::S_IDLE:
          if (accept) begin
            lst    <= last_char;
            inc_op <= in_op;
            if (is_digit) begin
              // saturate the literal at the largest value
              acc    <= (acc10 > (VW+5)'(iee_pkg::VAL_MAX)) ? iee_pkg::VAL_MAX
                                                              : acc10[VW-1:0];
              in_num <= 1'b1;
            end else if (is_op && in_num) begin
              if (opnd_cnt < NW'(STACK_DEPTH)) opnd_cnt <= opnd_cnt + NW'(1);
              else err <= iee_pkg::set_err(err, iee_pkg::ST_OVERFLOW);
              acc    <= '0;
              in_num <= 1'b0;
            end else begin
              err <= iee_pkg::set_err(err, iee_pkg::ST_MALFORMED);
            end
          end
        iee_pkg::S_FIN: begin
          flush <= 1'b1;
          if (!in_num) err <= iee_pkg::set_err(err, iee_pkg::ST_MALFORMED);
          else if (opnd_cnt < NW'(STACK_DEPTH)) opnd_cnt <= opnd_cnt + NW'(1);
          else err <= iee_pkg::set_err(err, iee_pkg::ST_OVERFLOW);
          in_num <= 1'b0;
        end
        iee_pkg::S_OPRD: red_op <= iee_pkg::op_t'(opr_rdata);
        iee_pkg::S_RED0: begin
          opr_cnt <= opr_cnt - NW'(1);
          if (opnd_cnt < NW'(2)) err <= iee_pkg::set_err(err, iee_pkg::ST_MALFORMED);
          rd_pend <= opnd_cnt != '0;
          if (opnd_cnt != '0) opnd_cnt <= opnd_cnt - NW'(1);
        end
        iee_pkg::S_RED1: begin
          opa     <= rd_pend ? $signed(opnd_rdata) : '0;
          rd_pend <= opnd_cnt != '0;
          if (opnd_cnt != '0) opnd_cnt <= opnd_cnt - NW'(1);
        end
        iee_pkg::S_RED2: opb <= rd_pend ? $signed(opnd_rdata) : '0;
        iee_pkg::S_WAIT:
          if (alu_rsp.done) begin
            if (alu_rsp.div_zero) err <= iee_pkg::set_err(err, iee_pkg::ST_DIV_ZERO);
            if (opnd_cnt < NW'(STACK_DEPTH)) opnd_cnt <= opnd_cnt + NW'(1);
            else err <= iee_pkg::set_err(err, iee_pkg::ST_OVERFLOW);
          end
        iee_pkg::S_PUSHOP:
          if (opr_cnt < NW'(STACK_DEPTH)) opr_cnt <= opr_cnt + NW'(1);
          else err <= iee_pkg::set_err(err, iee_pkg::ST_OVERFLOW);
        iee_pkg::S_TOP: rd_pend <= opnd_cnt != '0;
        iee_pkg::S_TOPW: opa <= rd_pend ? $signed(opnd_rdata) : '0;
        iee_pkg::S_EMIT:
          if (emit_go) begin
            out_valid <= 1'b1;
            value     <= opa;
            status    <= err;
            // clear for the next expression
            acc       <= '0;
            in_num    <= 1'b0;
            err       <= iee_pkg::ST_OK;
            opnd_cnt  <= '0;
            opr_cnt   <= '0;
            lst       <= 1'b0;
            flush     <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  iee_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_opnd_ram (
    .clk(clk), .we(opnd_we), .waddr(opnd_waddr), .wdata(opnd_wdata),
    .raddr(opnd_raddr), .rdata(opnd_rdata)
  );

  iee_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_opr_ram (
    .clk(clk), .we(opr_we), .waddr(opr_waddr), .wdata(inc_op),
    .raddr(opr_raddr), .rdata(opr_rdata)
  );

  iee_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .b(opb), .a(opa),
    .rsp(alu_rsp), .result(alu_res)
  );

`ifndef SYNTHESIS
  a_opnd_bound: assert property (@(posedge clk) disable iff (rst)
    opnd_cnt <= NW'(STACK_DEPTH) && opr_cnt <= NW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != iee_pkg::ST_OK && state != iee_pkg::S_EMIT) |=> err == $past(err))
    else $error("first error overwritten");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == iee_pkg::S_WAIT)
    else $error("alu result outside wait");
  a_digit_sets_num: assert property (@(posedge clk) disable iff (rst)
    (accept && is_digit) |=> in_num || state == iee_pkg::S_FIN)
    else $error("digit did not start a number");
`endif

endmodule
`default_nettype wire
